// File: src/mtrr_pkg.sv
// Shared types and constants for the MTRR MSR register file.
`default_nettype none

package mtrr_pkg;

  // Architectural MSR numbers.
  localparam logic [31:0] MSR_CAP     = 32'h0000_00FE;
  localparam logic [31:0] MSR_DEFTYPE = 32'h0000_02FF;
  localparam logic [31:0] MSR_FIX64K  = 32'h0000_0250;
  localparam logic [31:0] MSR_FIX16K  = 32'h0000_0258;
  localparam logic [31:0] MSR_FIX4K   = 32'h0000_0268;
  localparam logic [31:0] MSR_VARBASE = 32'h0000_0200;

  // Value masks.
  localparam logic [63:0] DEF_MASK   = 64'h0000_0000_0000_0CFF;
  localparam logic [63:0] TYPE_FIELD = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] MASK_VALID = 64'h0000_0000_0000_0800;
  localparam logic [63:0] PAGE_BITS  = 64'h0000_0000_0000_0FFF;
  localparam logic [63:0] CAP_BITS   = 64'h0000_0000_0000_0500;

  // Architectural memory type codes.
  localparam logic [7:0] MT_UC = 8'd0;
  localparam logic [7:0] MT_WC = 8'd1;
  localparam logic [7:0] MT_WT = 8'd4;
  localparam logic [7:0] MT_WP = 8'd5;
  localparam logic [7:0] MT_WB = 8'd6;

  // Allowed range of the guest physical address width.
  localparam logic [6:0] MIN_PHYS_WIDTH = 7'd36;
  localparam logic [6:0] MAX_PHYS_WIDTH = 7'd52;
  localparam logic [6:0] PHYS_WIDTH_RST = 7'd36;

  // Access kinds.
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Decoded access, passed from the decoder to the store and the result stage.
  typedef struct packed {
    logic       is_cap;
    logic       is_def;
    logic       is_fix4k;
    logic       is_fix16k;
    logic       is_fix64k;
    logic       is_var;
    logic       is_mask;
    logic [2:0] fix4k_idx;
    logic       fix16k_idx;
    logic       ok;
  } mtrr_dec_t;

endpackage

`default_nettype wire

// File: src/mtrr_decode.sv
// MSR number decode and write legality check for the MTRR register file.
`default_nettype none

module mtrr_decode
  import mtrr_pkg::*;
#(
  parameter int unsigned VAR_RANGES = 8,
  parameter int unsigned VR_IDX_W   = 3
) (
  input  wire logic                func_i,
  input  wire logic [31:0]         msr_index_i,
  input  wire logic [63:0]         write_data_i,
  input  wire logic [6:0]          phys_width_i,
  output mtrr_dec_t                dec_o,
  output logic      [VR_IDX_W-1:0] var_idx_o
);

  localparam logic [31:0] VAR_SPAN = 32'(2 * VAR_RANGES);

  function automatic logic type_ok(input logic [7:0] t);
    type_ok = (t == MT_UC) || (t == MT_WC) || (t == MT_WT) || (t == MT_WP) || (t == MT_WB);
  endfunction

  logic [31:0] var_off;
  logic [63:0] addr_field;
  logic        fixed_ok;
  logic        width_ok;
  logic        legal;
  logic        known;

  always_comb begin
    fixed_ok = 1'b1;
    for (int b = 0; b < 8; b++) begin
      fixed_ok = fixed_ok & type_ok(write_data_i[8*b +: 8]);
    end
  end

  assign var_off    = msr_index_i - MSR_VARBASE;
  assign addr_field = ((64'd1 << phys_width_i) - 64'd1) & ~PAGE_BITS;
  assign width_ok   = (phys_width_i >= MIN_PHYS_WIDTH) && (phys_width_i <= MAX_PHYS_WIDTH);

  always_comb begin
    dec_o            = '0;
    dec_o.is_cap     = (msr_index_i == MSR_CAP);
    dec_o.is_def     = (msr_index_i == MSR_DEFTYPE);
    dec_o.is_fix4k   = (msr_index_i[31:3] == MSR_FIX4K[31:3]);
    dec_o.is_fix16k  = (msr_index_i[31:1] == MSR_FIX16K[31:1]);
    dec_o.is_fix64k  = (msr_index_i == MSR_FIX64K);
    dec_o.is_var     = (msr_index_i >= MSR_VARBASE) && (var_off < VAR_SPAN);
    dec_o.is_mask    = var_off[0];
    dec_o.fix4k_idx  = msr_index_i[2:0];
    dec_o.fix16k_idx = msr_index_i[0];

    known = dec_o.is_def | dec_o.is_fix4k | dec_o.is_fix16k | dec_o.is_fix64k | dec_o.is_var;

    if (dec_o.is_def) begin
      legal = ((write_data_i & ~DEF_MASK) == 64'd0) && type_ok(write_data_i[7:0]);
    end else if (dec_o.is_var && !dec_o.is_mask) begin
      legal = ((write_data_i & ~(addr_field | TYPE_FIELD)) == 64'd0)
              && type_ok(write_data_i[7:0]);
    end else if (dec_o.is_var) begin
      legal = ((write_data_i & ~(addr_field | MASK_VALID)) == 64'd0);
    end else begin
      legal = fixed_ok;
    end

    if (func_i == FUNC_WRITE) begin
      dec_o.ok = width_ok & known & legal;
    end else begin
      dec_o.ok = known | dec_o.is_cap;
    end
  end

  assign var_idx_o = var_off[VR_IDX_W:1];

endmodule

`default_nettype wire

// File: src/mtrr_store.sv
// MTRR register storage with its write port and read select.
`default_nettype none

module mtrr_store
  import mtrr_pkg::*;
#(
  parameter int unsigned VAR_RANGES = 8,
  parameter int unsigned VR_IDX_W   = 3
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire mtrr_dec_t           dec_i,
  input  wire logic [VR_IDX_W-1:0] var_idx_i,
  input  wire logic [63:0]         write_data_i,
  output logic      [63:0]         read_data_o
);

  logic [11:0] def_q;
  logic [63:0] fix64k_q;
  logic [63:0] fix16k_q [2];
  logic [63:0] fix4k_q  [8];
  logic [63:0] base_q   [VAR_RANGES];
  logic [63:0] mask_q   [VAR_RANGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q    <= '0;
      fix64k_q <= '0;
      for (int i = 0; i < 2; i++) fix16k_q[i] <= '0;
      for (int i = 0; i < 8; i++) fix4k_q[i] <= '0;
      for (int i = 0; i < VAR_RANGES; i++) begin
        base_q[i] <= '0;
        mask_q[i] <= '0;
      end
    end else if (we_i) begin
      if (dec_i.is_def) begin
        def_q <= write_data_i[11:0];
      end
      if (dec_i.is_fix64k) begin
        fix64k_q <= write_data_i;
      end
      if (dec_i.is_fix16k) begin
        fix16k_q[dec_i.fix16k_idx] <= write_data_i;
      end
      if (dec_i.is_fix4k) begin
        fix4k_q[dec_i.fix4k_idx] <= write_data_i;
      end
      if (dec_i.is_var && !dec_i.is_mask) begin
        base_q[var_idx_i] <= write_data_i;
      end
      if (dec_i.is_var && dec_i.is_mask) begin
        mask_q[var_idx_i] <= write_data_i;
      end
    end
  end

  always_comb begin
    if (dec_i.is_cap) begin
      read_data_o = CAP_BITS | 64'(VAR_RANGES);
    end else if (dec_i.is_def) begin
      read_data_o = {52'd0, def_q};
    end else if (dec_i.is_fix4k) begin
      read_data_o = fix4k_q[dec_i.fix4k_idx];
    end else if (dec_i.is_fix16k) begin
      read_data_o = fix16k_q[dec_i.fix16k_idx];
    end else if (dec_i.is_fix64k) begin
      read_data_o = fix64k_q;
    end else if (dec_i.is_var && dec_i.is_mask) begin
      read_data_o = mask_q[var_idx_i];
    end else if (dec_i.is_var) begin
      read_data_o = base_q[var_idx_i];
    end else begin
      read_data_o = 64'd0;
    end
  end

endmodule

`default_nettype wire

// File: src/mtrr_msr_register_file_core.sv
// Top level of the MTRR MSR register file: handshakes, stage registers, assertions.
`default_nettype none

// The block holds the x86 memory-type-range MSR set of one virtual processor
// and serves one MSR access per item. An input item carries the access kind in
// tuser (0 read, 1 write) and the MSR number and write value in tdata; each
// item yields exactly one result item with the read value in tdata and the
// status in tuser (0 accepted, 1 rejected). Reads of unknown MSRs, writes of
// read-only or unknown MSRs and writes of illegal values are rejected, and
// every write is rejected while the width lies outside 36 to 52 bits; a
// rejected or write access returns zero read data. The block takes one item
// per clock cycle while its results are drained; an item is captured in an
// input register, decoded and checked against the register store in one
// pass of logic, and the result is held in an output register. Writes update
// the store as the item moves into the output register, so a read that
// follows a write sees the new value. The guest physical address width is
// set through the configuration channel, which is always ready and must
// only be written while no item is in flight. The valid flags and the
// register store are cleared at reset and the width resets to 36.
module mtrr_msr_register_file_core
  import mtrr_pkg::*;
#(
  parameter int unsigned VAR_RANGES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input items.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // [31:0] msr_index, [95:32] write_data
  input  wire logic [0:0]  s_axis_tuser,  // [0] func
  // Result items.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,  // [63:0] read_data
  output logic      [0:0]  m_axis_tuser,  // [0] status
  // Configuration write channel: physical address width.
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);

  localparam int unsigned VR_IDX_W = (VAR_RANGES > 1) ? $clog2(VAR_RANGES) : 1;

  // Configuration register.
  logic [6:0] phys_width_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phys_width_q <= PHYS_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      phys_width_q <= cfg_data_i;
    end
  end

  // Input register.
  logic        in_valid_q;
  logic        in_func_q;
  logic [31:0] in_msr_q;
  logic [63:0] in_wdata_q;

  // Output register.
  logic        out_valid_q;
  logic [63:0] out_rdata_q;
  logic        out_status_q;

  // The input stage moves forward whenever the output register is free or
  // being drained this cycle.
  logic advance;
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q  <= s_axis_tuser[0];
      in_msr_q   <= s_axis_tdata[31:0];
      in_wdata_q <= s_axis_tdata[95:32];
    end
  end

  // Decode and check the captured access.
  mtrr_dec_t             dec;
  logic [VR_IDX_W-1:0]   var_idx;
  logic [63:0]           store_rdata;
  logic                  store_we;

  mtrr_decode #(
    .VAR_RANGES (VAR_RANGES),
    .VR_IDX_W   (VR_IDX_W)
  ) u_decode (
    .func_i       (in_func_q),
    .msr_index_i  (in_msr_q),
    .write_data_i (in_wdata_q),
    .phys_width_i (phys_width_q),
    .dec_o        (dec),
    .var_idx_o    (var_idx)
  );

  // A legal write commits at the same edge that moves its result forward.
  assign store_we = in_valid_q && advance && (in_func_q == FUNC_WRITE) && dec.ok;

  mtrr_store #(
    .VAR_RANGES (VAR_RANGES),
    .VR_IDX_W   (VR_IDX_W)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (store_we),
    .dec_i        (dec),
    .var_idx_i    (var_idx),
    .write_data_i (in_wdata_q),
    .read_data_o  (store_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_status_q <= dec.ok ? STATUS_OK : STATUS_ERR;
      out_rdata_q  <= ((in_func_q == FUNC_READ) && dec.ok) ? store_rdata : 64'd0;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_rdata_q;
  assign m_axis_tuser[0] = out_status_q;

`ifndef ASSERT_OFF
  // A rejected access never returns data.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == STATUS_ERR) |-> (out_rdata_q == 64'd0))
    else $error("rejected result carries nonzero read data");

  // With the output register empty the block must take a new item.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready)
    else $error("input stalled while output register is empty");

  // A captured item that cannot move forward stays in the input register.
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_msr_q))
    else $error("stalled item lost from the input register");

  // Only a decoded, legal write may change the store.
  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (dec.is_def || dec.is_fix4k || dec.is_fix16k || dec.is_fix64k
                  || dec.is_var))
    else $error("store written for an MSR that is not writable");
`endif

endmodule

`default_nettype wire

// File: verif/mtrr_msr_register_file_core_test.sv
// Self-checking testbench for the MTRR MSR register file core.
`timescale 1ns / 100ps

module mtrr_msr_register_file_core_test;
  import mtrr_pkg::*;

  // Number of variable-range pairs built into the block under test.
  localparam int NUM_RANGES = 8;
  localparam int HALF_PERIOD = 6;
  // Percent of cycles in which each side idles outside the calm stretch.
  localparam int IDLE_PCT = 32;
  // Cycles to let pass after the last result before a width write.
  localparam int SETTLE_CYCLES = 3;
  // Cycles without any handshake after which the run is declared hung.
  localparam int STALL_LIMIT = 1000;
  // Length of the single long receiver hold-off, and when it starts.
  localparam int HOLD_CYCLES = 80;
  localparam int HOLD_AT_ITEM = 120;
  // Accepted-item window in which neither side idles.
  localparam int CALM_FROM = 300;
  localparam int CALM_TO = 440;

  // One step of the plan: an MSR access, a width write, or a pause until all
  // outstanding results have come back.
  typedef enum logic [1:0] {JOB_ACCESS, JOB_WIDTH, JOB_DRAIN} job_kind_e;

  typedef struct {
    job_kind_e   kind;
    logic        func;
    logic [31:0] msr;
    logic [63:0] wdata;
    logic [6:0]  width;
  } msr_job_t;

  typedef struct {
    logic [63:0] read_data;
    logic        status;
  } msr_reply_t;

  // Block ports; the inputs driven here are at known values from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;  // [31:0] msr_index, [95:32] write_data
  logic [0:0]  s_axis_tuser = '0;  // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // [63:0] read_data
  logic [0:0]  m_axis_tuser;       // [0] status
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i = '0;

  // Shadow copy of the register file and of the width register.
  logic [6:0]  phys_width_q = PHYS_WIDTH_RST;
  logic [11:0] deftype_q;
  logic [63:0] fix64k_q;
  logic [63:0] fix16k_q [2];
  logic [63:0] fix4k_q [8];
  logic [63:0] var_base_q [NUM_RANGES];
  logic [63:0] var_mask_q [NUM_RANGES];

  msr_job_t   access_plan [$];
  msr_reply_t reply_q [$];

  // Handshake flags seen at the last rising edge, read by the falling-edge
  // processes.
  logic access_taken = 1'b0;
  logic width_taken = 1'b0;
  int   settle_cnt = 0;
  int   stall_cnt = 0;
  int   n_accepted = 0;
  int   n_reads = 0;
  int   n_writes = 0;
  int   n_rejects = 0;
  int   n_results = 0;
  int   n_widths = 0;
  int   mismatches = 0;
  logic calm;

  assign calm = (n_accepted >= CALM_FROM) && (n_accepted < CALM_TO);

  mtrr_msr_register_file_core #(
    .VAR_RANGES(NUM_RANGES)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Register file predictor.
  // ---------------------------------------------------------------------------

  function automatic logic type_ok(input logic [7:0] t);
    case (t)
      MT_UC, MT_WC, MT_WT, MT_WP, MT_WB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Fixed-range registers hold eight memory types, one per byte.
  function automatic logic fixed_ok(input logic [63:0] v);
    for (int i = 0; i < 8; i++) begin
      if (!type_ok(v[i*8 +: 8])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic in_span(input logic [31:0] msr, input logic [31:0] first,
                                   input int unsigned count);
    return (msr >= first) && ((msr - first) < count);
  endfunction

  // Address bits from 12 up to the physical width.
  function automatic logic [63:0] phys_bits(input logic [6:0] w);
    return ((64'd1 << w) - 64'd1) & ~PAGE_BITS;
  endfunction

  // Works out the reply to one access and applies an accepted write to the
  // shadow registers.
  function automatic msr_reply_t predict_access(input logic func, input logic [31:0] msr,
                                                input logic [63:0] v);
    msr_reply_t  r;
    logic        ok;
    logic [63:0] phys;
    logic [31:0] off;
    int          slot;
    r.read_data = '0;
    ok = 1'b0;
    off = msr - MSR_VARBASE;
    slot = int'(off >> 1);
    if (func == FUNC_READ) begin
      ok = 1'b1;
      if (msr == MSR_CAP) r.read_data = CAP_BITS | NUM_RANGES;
      else if (msr == MSR_DEFTYPE) r.read_data = {52'd0, deftype_q};
      else if (in_span(msr, MSR_FIX4K, 8)) r.read_data = fix4k_q[msr[2:0] - MSR_FIX4K[2:0]];
      else if (in_span(msr, MSR_FIX16K, 2)) r.read_data = fix16k_q[msr[0] ^ MSR_FIX16K[0]];
      else if (msr == MSR_FIX64K) r.read_data = fix64k_q;
      else if (in_span(msr, MSR_VARBASE, 2 * NUM_RANGES))
        r.read_data = off[0] ? var_mask_q[slot] : var_base_q[slot];
      else ok = 1'b0;
    end else if (phys_width_q >= MIN_PHYS_WIDTH && phys_width_q <= MAX_PHYS_WIDTH) begin
      // An out-of-range width rejects every write, known MSR or not.
      phys = phys_bits(phys_width_q);
      if (msr == MSR_DEFTYPE) begin
        ok = ((v & ~DEF_MASK) == '0) && type_ok(v[7:0]);
        if (ok) deftype_q = v[11:0];
      end else if (in_span(msr, MSR_FIX4K, 8)) begin
        ok = fixed_ok(v);
        if (ok) fix4k_q[msr[2:0] - MSR_FIX4K[2:0]] = v;
      end else if (in_span(msr, MSR_FIX16K, 2)) begin
        ok = fixed_ok(v);
        if (ok) fix16k_q[msr[0] ^ MSR_FIX16K[0]] = v;
      end else if (msr == MSR_FIX64K) begin
        ok = fixed_ok(v);
        if (ok) fix64k_q = v;
      end else if (in_span(msr, MSR_VARBASE, 2 * NUM_RANGES)) begin
        if (off[0]) begin
          ok = (v & ~(phys | MASK_VALID)) == '0;
          if (ok) var_mask_q[slot] = v;
        end else begin
          ok = ((v & ~(phys | TYPE_FIELD)) == '0) && type_ok(v[7:0]);
          if (ok) var_base_q[slot] = v;
        end
      end
    end
    r.status = ok ? STATUS_OK : STATUS_ERR;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] pick_type();
    case ($urandom_range(4))
      0: return MT_UC;
      1: return MT_WC;
      2: return MT_WT;
      3: return MT_WP;
      default: return MT_WB;
    endcase
  endfunction

  // A value that the addressed register accepts at width w, random elsewhere.
  function automatic logic [63:0] legal_value(input logic [31:0] msr, input logic [6:0] w);
    logic [63:0] v;
    logic [63:0] phys;
    if (w < MIN_PHYS_WIDTH || w > MAX_PHYS_WIDTH) phys = phys_bits(MAX_PHYS_WIDTH);
    else phys = phys_bits(w);
    v = {$urandom, $urandom};
    if (msr == MSR_DEFTYPE) begin
      v = (v & DEF_MASK & ~TYPE_FIELD) | pick_type();
    end else if (in_span(msr, MSR_VARBASE, 2 * NUM_RANGES)) begin
      if (msr[0]) v = v & (phys | MASK_VALID);
      else v = (v & phys) | pick_type();
    end else begin
      for (int i = 0; i < 8; i++) v[i*8 +: 8] = pick_type();
    end
    return v;
  endfunction

  // MSR numbers just outside the decoded windows, and one with a high bit set
  // that must not alias onto the default type register.
  function automatic logic [31:0] near_miss();
    case ($urandom_range(9))
      0: return MSR_CAP - 1;
      1: return MSR_CAP + 1;
      2: return MSR_VARBASE - 1;
      3: return MSR_VARBASE + 2 * NUM_RANGES;
      4: return MSR_FIX64K + 1;
      5: return MSR_FIX16K - 1;
      6: return MSR_FIX16K + 2;
      7: return MSR_FIX4K - 1;
      8: return MSR_FIX4K + 8;
      default: return MSR_DEFTYPE | 32'h8000_0000;
    endcase
  endfunction

  function automatic msr_job_t random_access(input logic [6:0] w);
    msr_job_t j;
    int       r;
    j.kind = JOB_ACCESS;
    j.width = '0;
    j.func = ($urandom_range(1) == 0) ? FUNC_READ : FUNC_WRITE;
    r = $urandom_range(99);
    if (r < 80) begin
      case ($urandom_range(6))
        0: j.msr = MSR_CAP;
        1: j.msr = MSR_DEFTYPE;
        2: j.msr = MSR_FIX64K;
        3: j.msr = MSR_FIX16K + $urandom_range(1);
        4: j.msr = MSR_FIX4K + $urandom_range(7);
        default: j.msr = MSR_VARBASE + $urandom_range(2 * NUM_RANGES - 1);
      endcase
    end else if (r < 92) begin
      j.msr = near_miss();
    end else begin
      j.msr = $urandom;
    end
    // Mostly legal values so the store fills up; the rest are one bit off a
    // legal value or plain noise.
    r = $urandom_range(99);
    j.wdata = legal_value(j.msr, w);
    if (r >= 88) j.wdata = {$urandom, $urandom};
    else if (r >= 70) j.wdata = j.wdata ^ (64'd1 << $urandom_range(63));
    return j;
  endfunction

  task automatic add_access(input logic func, input logic [31:0] msr, input logic [63:0] v);
    msr_job_t j;
    j.kind = JOB_ACCESS;
    j.func = func;
    j.msr = msr;
    j.wdata = v;
    j.width = '0;
    access_plan.push_back(j);
  endtask

  task automatic add_pause(input job_kind_e kind, input logic [6:0] w);
    msr_job_t j;
    j.kind = kind;
    j.func = FUNC_READ;
    j.msr = '0;
    j.wdata = '0;
    j.width = w;
    access_plan.push_back(j);
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Sender. At each falling edge it retires the item taken at the last rising
  // edge and offers the next one from the plan, unless it idles this cycle.
  // Width writes and pauses wait until no result is outstanding.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed_proc
    msr_job_t head;
    logic     next_valid;
    logic     next_cfg;
    next_valid = s_axis_tvalid;
    next_cfg = cfg_valid_i;
    if (rst_ni) begin
      if (access_taken) next_valid = 1'b0;
      if (width_taken) next_cfg = 1'b0;
      if (!next_valid && !next_cfg && access_plan.size() != 0) begin
        head = access_plan[0];
        case (head.kind)
          JOB_ACCESS: begin
            if (calm || $urandom_range(99) >= IDLE_PCT) begin
              next_valid = 1'b1;
              s_axis_tdata <= {head.wdata, head.msr};
              s_axis_tuser <= head.func;
              void'(access_plan.pop_front());
            end
          end
          JOB_WIDTH: begin
            if (reply_q.size() == 0 && settle_cnt >= SETTLE_CYCLES) begin
              next_cfg = 1'b1;
              cfg_data_i <= head.width;
              void'(access_plan.pop_front());
            end
          end
          default: begin
            if (reply_q.size() == 0) void'(access_plan.pop_front());
          end
        endcase
      end
    end
    s_axis_tvalid <= next_valid;
    cfg_valid_i <= next_cfg;
  end

  // ---------------------------------------------------------------------------
  // Receiver. Random back-pressure, none in the calm stretch, and one long
  // hold-off during which the sender keeps offering so the block backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : sink_proc
    int   hold_left;
    logic hold_done;
    if (!rst_ni) begin
      hold_left = 0;
      hold_done = 1'b0;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT_ITEM) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. At each rising edge it predicts accepted accesses, tracks width
  // writes, checks results against the oldest prediction, and watches for a
  // hung block.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_proc
    msr_reply_t want;
    logic       result_taken;
    access_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    width_taken = rst_ni && cfg_valid_i && cfg_ready_o;
    result_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (access_taken) begin
      want = predict_access(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[95:32]);
      reply_q.push_back(want);
      n_accepted++;
      if (s_axis_tuser[0] == FUNC_READ) n_reads++;
      else n_writes++;
      if (want.status == STATUS_ERR) n_rejects++;
    end
    if (width_taken) begin
      phys_width_q = cfg_data_i;
      n_widths++;
    end
    if (result_taken) begin
      n_results++;
      if (reply_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: data %h status %0d",
                                  m_axis_tdata, m_axis_tuser[0]));
      end else begin
        want = reply_q.pop_front();
        if (m_axis_tdata !== want.read_data)
          report_mismatch($sformatf("result %0d read_data %h, expected %h",
                                    n_results, m_axis_tdata, want.read_data));
        if (m_axis_tuser[0] !== want.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                    n_results, m_axis_tuser[0], want.status));
      end
    end
    if (reply_q.size() == 0 && !access_taken) settle_cnt++;
    else settle_cnt = 0;
    if (!rst_ni || access_taken || width_taken || result_taken) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               stall_cnt, reply_q.size());
      $display("mtrr_msr_register_file_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin : plan_proc
    logic [6:0] widths [8];
    int         count;
    deftype_q = '0;
    fix64k_q = '0;
    foreach (fix16k_q[i]) fix16k_q[i] = '0;
    foreach (fix4k_q[i]) fix4k_q[i] = '0;
    foreach (var_base_q[i]) var_base_q[i] = '0;
    foreach (var_mask_q[i]) var_mask_q[i] = '0;

    // Directed part at the reset width of 36 bits: the capability register,
    // each register class with a legal value and all but the 16K range with an
    // illegal one, the edges of the variable windows and unknown numbers.
    add_access(FUNC_READ,  MSR_CAP, '0);
    add_access(FUNC_WRITE, MSR_CAP, 64'h0508);
    add_access(FUNC_READ,  MSR_DEFTYPE, '1);
    add_access(FUNC_WRITE, MSR_DEFTYPE, 64'h0C06);
    add_access(FUNC_WRITE, MSR_DEFTYPE, 64'h1006);
    add_access(FUNC_WRITE, MSR_DEFTYPE, 64'h0002);
    add_access(FUNC_WRITE, MSR_DEFTYPE, '1);
    add_access(FUNC_READ,  MSR_DEFTYPE, '0);
    add_access(FUNC_WRITE, MSR_FIX64K, 64'h0606_0606_0606_0606);
    add_access(FUNC_WRITE, MSR_FIX64K, 64'h0706_0606_0606_0606);
    add_access(FUNC_READ,  MSR_FIX64K, '0);
    add_access(FUNC_WRITE, MSR_FIX16K + 1, 64'h0504_0100_0504_0100);
    add_access(FUNC_READ,  MSR_FIX16K + 1, '0);
    add_access(FUNC_WRITE, MSR_FIX4K + 7, '1);
    add_access(FUNC_WRITE, MSR_FIX4K + 7, 64'h0001_0405_0600_0104);
    add_access(FUNC_READ,  MSR_FIX4K + 7, '0);
    add_access(FUNC_WRITE, MSR_VARBASE, 64'h0000_000F_FFFF_F006);
    add_access(FUNC_WRITE, MSR_VARBASE, 64'h0000_0010_0000_0006);
    add_access(FUNC_WRITE, MSR_VARBASE + 2 * NUM_RANGES - 1, 64'h0000_000F_FFFF_F800);
    add_access(FUNC_WRITE, MSR_VARBASE + 2 * NUM_RANGES - 1, 64'h0000_000F_FFFF_FC00);
    add_access(FUNC_READ,  MSR_VARBASE, '0);
    add_access(FUNC_READ,  MSR_VARBASE + 2 * NUM_RANGES - 1, '0);
    add_access(FUNC_READ,  32'hFFFF_FFFF, '0);
    add_access(FUNC_WRITE, MSR_VARBASE + 2 * NUM_RANGES, '0);
    add_access(FUNC_READ,  32'h0000_0000, '0);

    // Random phases, each at its own width. In-range widths get long phases
    // so the store fills with legal content; widths outside the range, where
    // every write is turned away, get short ones.
    widths = '{7'd52, 7'd0, 7'd44, 7'd127, 7'd35, 7'd53, 7'd64, 7'd36};
    foreach (widths[p]) begin
      add_pause(JOB_WIDTH, widths[p]);
      count = (widths[p] >= MIN_PHYS_WIDTH && widths[p] <= MAX_PHYS_WIDTH) ? 200 : 50;
      for (int i = 0; i < count; i++) begin
        // One mid-phase pause where the sender waits for the block to empty.
        if (p == 2 && i == 60) add_pause(JOB_DRAIN, '0);
        access_plan.push_back(random_access(widths[p]));
      end
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (access_plan.size() != 0 || s_axis_tvalid || cfg_valid_i || reply_q.size() != 0)
      @(negedge clk_i);
    // Anything that shows up now has no prediction and is flagged.
    repeat (4 * SETTLE_CYCLES) @(negedge clk_i);

    $display("Ran %0d MSR accesses (%0d reads, %0d writes, %0d expected rejections)",
             n_accepted, n_reads, n_writes, n_rejects);
    $display("over %0d width settings; %0d results checked, %0d mismatches",
             n_widths + 1, n_results, mismatches);
    if (mismatches == 0) begin
      $display("mtrr_msr_register_file_core test passed");
    end else begin
      $display("mtrr_msr_register_file_core test failed");
    end
    $finish;
  end

endmodule
